// File: rtl/bphc_pkg.sv
`default_nettype none
package bphc_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 8;
    localparam int VALUE_W     = 32;
    localparam int FIELD_VAL_W = 32;

    // probe chain length
    localparam int PROBE_LIMIT = 5;
    localparam int PROBE_CNT_W = $clog2(PROBE_LIMIT + 1);

    // slot map constants
    localparam int HASH_MUL = 37;
    localparam int HASH_ADD = 127;

    // operation codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // request item
    typedef struct packed {
        logic                   func;
        logic [KEY_W-1:0]       key;
        logic [FIELD_VAL_W-1:0] value_in;
    } req_t;

    // response item
    typedef struct packed {
        logic                   hit;
        logic [FIELD_VAL_W-1:0] value_out;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
        logic finish;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic found;
    } status_t;

    // slot map: x*37 + 127 mod table depth
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] x);
        logic [2*SLOT_W-1:0] prod;
        begin
            prod = (2*SLOT_W)'(x) * (2*SLOT_W)'(HASH_MUL) + (2*SLOT_W)'(HASH_ADD);
            return prod[SLOT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/bphc_ram.sv
`default_nettype none
module bphc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/bphc_ctrl.sv
`default_nettype none
module bphc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    input  wire bphc_pkg::status_t sts,
    output bphc_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [bphc_pkg::PROBE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    logic                             last_probe;
    logic                             out_free;

    assign last_probe = (cnt_reg == bphc_pkg::PROBE_CNT_W'(bphc_pkg::PROBE_LIMIT - 1));
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.step   = 1'b1;
                cnt_next   = '0;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.found || last_probe)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result slot occupancy
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

// File: rtl/bphc_dp.sv
`default_nettype none
module bphc_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bphc_pkg::req_t req,
    input  wire bphc_pkg::cmd_t cmd,
    output bphc_pkg::status_t   sts,
    output bphc_pkg::rsp_t      rsp
);

    localparam int ENTRY_W = bphc_pkg::KEY_W + bphc_pkg::VALUE_W;

    logic                             op_reg;
    logic [bphc_pkg::KEY_W-1:0]       key_reg;
    logic [bphc_pkg::VALUE_W-1:0]     val_reg;
    logic [bphc_pkg::SLOT_W-1:0]      first_reg;
    logic [bphc_pkg::SLOT_W-1:0]      addr_reg;
    logic [bphc_pkg::SLOT_W-1:0]      prev_reg;
    logic                             vld_rd_reg;
    logic [bphc_pkg::SLOT_W-1:0]      tgt_reg;
    logic                             found_reg;
    logic [bphc_pkg::VALUE_W-1:0]     res_val_reg;
    bphc_pkg::rsp_t                   rsp_reg;
    logic [bphc_pkg::TABLE_DEPTH-1:0] valid_reg;

    logic [ENTRY_W-1:0]               rd_entry;
    logic [bphc_pkg::KEY_W-1:0]       rd_key;
    logic [bphc_pkg::VALUE_W-1:0]     rd_val;
    logic                             key_eq;
    logic                             wr_en;

    assign rd_key = rd_entry[ENTRY_W-1:bphc_pkg::VALUE_W];
    assign rd_val = rd_entry[bphc_pkg::VALUE_W-1:0];
    assign key_eq = (rd_key == key_reg);
    assign wr_en  = cmd.finish && (op_reg == bphc_pkg::FUNC_INSERT);

    // insert stops on a free or same-key slot, lookup on a valid match
    assign sts.found = (op_reg == bphc_pkg::FUNC_INSERT) ? (!vld_rd_reg || key_eq)
                                                         : (vld_rd_reg && key_eq);

    // key and value store
    bphc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (bphc_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (tgt_reg),
        .wdata ({key_reg, val_reg}),
        .re    (cmd.step),
        .raddr (addr_reg),
        .rdata (rd_entry)
    );

    // item capture and probe address walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req.func;
            key_reg   <= req.key;
            val_reg   <= bphc_pkg::VALUE_W'(req.value_in);
            first_reg <= bphc_pkg::next_slot(req.key);
            addr_reg  <= bphc_pkg::next_slot(req.key);
        end
        else if (cmd.step)
        begin
            addr_reg <= bphc_pkg::next_slot(addr_reg);
        end
        if (cmd.step)
        begin
            prev_reg   <= addr_reg;
            vld_rd_reg <= valid_reg[addr_reg];
        end
    end

    // probe outcome
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            found_reg   <= sts.found;
            tgt_reg     <= sts.found ? prev_reg : first_reg;
            res_val_reg <= rd_val;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.hit <= (op_reg == bphc_pkg::FUNC_INSERT) || found_reg;
            rsp_reg.value_out <= ((op_reg == bphc_pkg::FUNC_LOOKUP) && found_reg)
                                 ? bphc_pkg::FIELD_VAL_W'(res_val_reg) : '0;
        end
    end

    // slot valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[tgt_reg] <= 1'b1;
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

// File: rtl/bounded_probe_hash_cache_top.sv
`default_nettype none
// channel   valid      stall      payload
// request   req_valid  req_stall  req (func, key, value_in)
// response  rsp_valid  rsp_stall  rsp (hit, value_out)
//
// one item at a time: accept, first read, then one table read per probe
// (up to 5) through the single registered ram port, then commit of the
// result; a new item is taken while a result waits
// reset clears the slot valid marks at once; no clearing pass
// a stalled result holds the commit of the next item until it is taken
module bounded_probe_hash_cache_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bphc_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output bphc_pkg::rsp_t      rsp
);

    bphc_pkg::cmd_t    cmd;
    bphc_pkg::status_t sts;

    // sequencer
    bphc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table and result datapath
    bphc_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

    // an accepted item closes the request side on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side open while an item is in progress");

    // commit always presents a result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid)
        else $error("commit without a result item");

    // a miss carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp.value_out == '0)
        else $error("miss result with nonzero value");

    // probe reads never overlap a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.finish))
        else $error("probe read during commit");

endmodule
`default_nettype wire
